// ===== hw/rtl/stsfl_pkg.sv =====
package stsfl_pkg;

    localparam int SLOT_COUNT_DEFAULT = 256;
    localparam int WORD_WIDTH_DEFAULT = 32;
    localparam int OP_WIDTH = 3;
    localparam int IDX_WIDTH = 8;
    localparam int STATUS_WIDTH = 2;
    localparam int NUM_WORDS = 6;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ADD    = 3'd0,
        OP_FIND   = 3'd1,
        OP_GET    = 3'd2,
        OP_MODIFY = 3'd3,
        OP_DELETE = 3'd4
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_OCC   = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic read_slot;
        logic read_link;
        logic link_from_prev;
        logic do_add;
        logic do_modify;
        logic del_head;
        logic del_link;
        logic step_walk;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic   in_range;
        logic   occupied;
        logic   below_head;
        logic   walk_stop;
        logic   walk_dead;
        op_t    op;
    } stat_t;

endpackage

// ===== hw/rtl/stsfl_ctrl.sv =====
module stsfl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output stsfl_pkg::cmd_t  cmd,
    input  stsfl_pkg::stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_WALK_RD,
        S_WALK_CHK,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read_slot = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (stat.op == stsfl_pkg::OP_ADD)
                begin
                    cmd.do_add = 1'b1;
                end
                else if (stat.op == stsfl_pkg::OP_MODIFY && stat.in_range && stat.occupied)
                begin
                    cmd.do_modify = 1'b1;
                end
                else if (stat.op == stsfl_pkg::OP_DELETE && stat.in_range && stat.occupied)
                begin
                    if (stat.below_head)
                    begin
                        cmd.del_head = 1'b1;
                    end
                    else
                    begin
                        cmd.read_link = 1'b1;
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD:
            begin
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                priority if (stat.walk_dead)
                begin
                    state_next = S_DONE;
                end
                else if (stat.walk_stop)
                begin
                    cmd.del_link = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step_walk = 1'b1;
                    cmd.read_link = 1'b1;
                    cmd.link_from_prev = 1'b1;
                    state_next = S_WALK_RD;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hw/rtl/stsfl_datapath.sv =====
module stsfl_datapath #(
    parameter int SLOT_COUNT = stsfl_pkg::SLOT_COUNT_DEFAULT,
    parameter int WORD_WIDTH = stsfl_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stsfl_pkg::cmd_t                      cmd,
    output stsfl_pkg::stat_t                     stat,
    input  logic [stsfl_pkg::OP_WIDTH-1:0]       operation,
    input  logic [stsfl_pkg::IDX_WIDTH-1:0]      slot_index,
    input  logic [stsfl_pkg::NUM_WORDS*WORD_WIDTH-1:0] in_words,
    output logic                                 done,
    output logic [stsfl_pkg::STATUS_WIDTH-1:0]   status,
    output logic [stsfl_pkg::IDX_WIDTH-1:0]      result_slot,
    output logic                                 is_occupied,
    output logic [stsfl_pkg::NUM_WORDS*WORD_WIDTH-1:0] out_words
);

    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PW = stsfl_pkg::NUM_WORDS * WORD_WIDTH;
    localparam int IW = stsfl_pkg::IDX_WIDTH;
    localparam logic [CW-1:0] SLOTS = CW'(SLOT_COUNT);

    logic [PW-1:0] payload_mem [SLOT_COUNT];
    logic [CW-1:0] link_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] occ_reg;

    logic [CW-1:0] used_reg;
    logic [CW-1:0] head_reg;
    logic [CW-1:0] walk_reg;
    logic [CW-1:0] steps_reg;
    logic [CW-1:0] link_rd_reg;
    logic [PW-1:0] pay_rd_reg;
    logic [PW-1:0] in_reg;
    logic [IW-1:0] idx_reg;
    stsfl_pkg::op_t op_reg;

    logic [CW-1:0] idx_ext;
    logic [CW-1:0] add_slot;
    logic          add_from_list;
    logic          add_full;
    logic [CW-1:0] walk_src;
    logic [CW-1:0] rd_addr;
    logic          known_op;

    assign idx_ext = CW'(idx_reg);
    assign add_from_list = (head_reg < used_reg);
    assign add_full = !add_from_list && (used_reg >= SLOTS);
    assign add_slot = add_from_list ? head_reg : used_reg;
    assign walk_src = cmd.link_from_prev ? link_rd_reg : head_reg;
    assign rd_addr = cmd.read_link ? walk_src : idx_ext;
    assign known_op = (op_reg <= stsfl_pkg::OP_DELETE);

    assign stat.op = op_reg;
    assign stat.in_range = idx_ext < used_reg;
    assign stat.occupied = (idx_ext < SLOTS) ? occ_reg[idx_ext[AW-1:0]] : 1'b0;
    assign stat.below_head = idx_ext < head_reg;
    assign stat.walk_stop = (link_rd_reg >= used_reg) || (link_rd_reg > idx_ext);
    assign stat.walk_dead = (walk_reg >= SLOTS) || (steps_reg >= SLOTS);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_reg <= in_words;
            idx_reg <= slot_index;
            op_reg <= stsfl_pkg::op_t'(operation);
        end
        if (cmd.read_slot)
        begin
            pay_rd_reg <= payload_mem[idx_ext[AW-1:0]];
        end
        if (cmd.read_link)
        begin
            link_rd_reg <= link_mem[rd_addr[AW-1:0]];
        end
        if (cmd.do_add && !add_full)
        begin
            payload_mem[add_slot[AW-1:0]] <= in_reg;
        end
        if (cmd.do_modify)
        begin
            payload_mem[idx_ext[AW-1:0]] <= in_reg;
        end
        if (cmd.del_head)
        begin
            link_mem[idx_ext[AW-1:0]] <= head_reg;
        end
        if (cmd.del_link)
        begin
            link_mem[idx_ext[AW-1:0]] <= (link_rd_reg >= used_reg) ? used_reg : link_rd_reg;
            link_mem[walk_reg[AW-1:0]] <= idx_ext;
        end
    end

    // add reads the head link under read_slot, at the head address, the cycle before it is used
    logic [CW-1:0] head_link_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.read_slot)
        begin
            head_link_reg <= link_mem[head_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            head_reg <= '0;
            occ_reg <= '0;
            walk_reg <= '0;
            steps_reg <= '0;
            done <= 1'b0;
            status <= '0;
            result_slot <= '0;
            is_occupied <= 1'b0;
            out_words <= '0;
        end
        else
        begin
            done <= cmd.finish;
            if (cmd.latch_in)
            begin
                walk_reg <= '0;
                steps_reg <= '0;
                status <= stsfl_pkg::ST_OK;
                result_slot <= slot_index;
                is_occupied <= 1'b0;
                out_words <= '0;
            end
            if (cmd.read_link && !cmd.link_from_prev)
            begin
                walk_reg <= head_reg;
            end
            if (cmd.step_walk)
            begin
                walk_reg <= link_rd_reg;
                steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.do_add)
            begin
                if (add_full)
                begin
                    status <= stsfl_pkg::ST_FULL;
                    result_slot <= '0;
                end
                else
                begin
                    occ_reg[add_slot[AW-1:0]] <= 1'b1;
                    result_slot <= add_slot[IW-1:0];
                    is_occupied <= 1'b1;
                    if (add_from_list)
                    begin
                        head_reg <= head_link_reg;
                    end
                    else
                    begin
                        used_reg <= used_reg + 1'b1;
                        head_reg <= used_reg + 1'b1;
                    end
                end
            end
            else if (cmd.read_slot && known_op && op_reg != stsfl_pkg::OP_ADD)
            begin
                if (!stat.in_range)
                begin
                    status <= stsfl_pkg::ST_RANGE;
                end
                else if (!stat.occupied)
                begin
                    status <= stsfl_pkg::ST_NOT_OCC;
                end
                else
                begin
                    is_occupied <= (op_reg != stsfl_pkg::OP_DELETE);
                end
            end
            if (cmd.finish && op_reg == stsfl_pkg::OP_GET && status == stsfl_pkg::ST_OK
                && is_occupied)
            begin
                out_words <= pay_rd_reg;
            end
            if ((cmd.del_head || cmd.read_link) && !cmd.link_from_prev)
            begin
                occ_reg[idx_ext[AW-1:0]] <= 1'b0;
            end
            if (cmd.del_head)
            begin
                head_reg <= idx_ext;
            end
        end
    end

endmodule

// ===== hw/rtl/slot_table_sorted_free_list.sv =====
// record slot table with a sorted free list
// command channel: drive operation, slot_index and the six payload words
// with start high; the command transfers at the rising edge where start is
// high and busy is low. busy drops in the cycle where done pulses.
// result channel: done pulses for one cycle with status, result_slot,
// is_occupied and the get payload; the receiver cannot stall, so the
// result must be captured in that cycle.
// operations: add (lowest free slot or append), find, get, modify, delete
// sequence: add, find, get, modify and a delete that needs no walk pass through
// the read, decide and done states before done rises; a delete that walks the
// free chain adds a walk-read and a walk-check state per link visited, and stops
// where the slot belongs in the chain or when its step count reaches SLOT_COUNT.
// one command at a time; the next may transfer at the edge that ends the
// done cycle.
// reset clears the used count, list head and all occupied marks; payload
// and link memories are not cleared and are only used once written.
module slot_table_sorted_free_list #(
    parameter int SLOT_COUNT = stsfl_pkg::SLOT_COUNT_DEFAULT,
    parameter int WORD_WIDTH = stsfl_pkg::WORD_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [stsfl_pkg::OP_WIDTH-1:0]     operation,
    input  logic [stsfl_pkg::IDX_WIDTH-1:0]    slot_index,
    input  logic [WORD_WIDTH-1:0]              positive_articles,
    input  logic [WORD_WIDTH-1:0]              negative_articles,
    input  logic [WORD_WIDTH-1:0]              positive_words,
    input  logic [WORD_WIDTH-1:0]              negative_words,
    input  logic [WORD_WIDTH-1:0]              tag_block_offset,
    input  logic [WORD_WIDTH-1:0]              empty_block_offset,
    output logic                               done,
    output logic [stsfl_pkg::STATUS_WIDTH-1:0] status,
    output logic [stsfl_pkg::IDX_WIDTH-1:0]    result_slot,
    output logic                               is_occupied,
    output logic [WORD_WIDTH-1:0]              out_positive_articles,
    output logic [WORD_WIDTH-1:0]              out_negative_articles,
    output logic [WORD_WIDTH-1:0]              out_positive_words,
    output logic [WORD_WIDTH-1:0]              out_negative_words,
    output logic [WORD_WIDTH-1:0]              out_tag_block_offset,
    output logic [WORD_WIDTH-1:0]              out_empty_block_offset
);

    stsfl_pkg::cmd_t  cmd;
    stsfl_pkg::stat_t stat;
    logic [stsfl_pkg::NUM_WORDS*WORD_WIDTH-1:0] in_words;
    logic [stsfl_pkg::NUM_WORDS*WORD_WIDTH-1:0] out_words;

    assign in_words = {empty_block_offset, tag_block_offset, negative_words,
                       positive_words, negative_articles, positive_articles};
    assign {out_empty_block_offset, out_tag_block_offset, out_negative_words,
            out_positive_words, out_negative_articles, out_positive_articles} = out_words;

    stsfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    stsfl_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .slot_index  (slot_index),
        .in_words    (in_words),
        .done        (done),
        .status      (status),
        .result_slot (result_slot),
        .is_occupied (is_occupied),
        .out_words   (out_words)
    );

endmodule
